[rtl/ctc_digit_greedy_decoder_unit_macros.svh]
// Assertion macros shared by the checker of the CTC digit decoder.
`ifndef CTC_DIGIT_GREEDY_DECODER_UNIT_MACROS_SVH
`define CTC_DIGIT_GREEDY_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CTCDG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctcdg assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CTCDG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctcdg assertion failed");

`endif

[rtl/ctcdg_pkg.sv]
// Shared constants and types of the CTC digit greedy decoder.
`timescale 1ns / 1ps

package ctcdg_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned SCORE_W  = 8;
	localparam int unsigned NUMBER_W = 31;
	// Headroom for accumulator * 10 + digit before the saturation check.
	localparam int unsigned WIDE_W   = NUMBER_W + 4;

	localparam int unsigned DEFAULT_MAX_CLASSES = 16;
	localparam int unsigned QUEUE_DEPTH         = 2;

	localparam logic [NUMBER_W-1:0] NUMBER_MAX   = {NUMBER_W{1'b1}};
	localparam logic [3:0]          DECIMAL_BASE = 4'd10;
	localparam int unsigned         BLANK_INDEX  = 0;

	// Status of the symbol queue as seen by the front and back parts.
	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

[rtl/ctcdg_score_if.sv]
// Score input channel: one class score per beat.
`timescale 1ns / 1ps

interface ctcdg_score_if;
	logic                                valid;
	logic                                ready;
	logic signed [ctcdg_pkg::SCORE_W-1:0] score;
	logic                                class_last;
	logic                                step_last;

	modport source (output valid, output score, output class_last, output step_last,
		input ready);
	modport sink (input valid, input score, input class_last, input step_last,
		output ready);
endinterface

[rtl/ctcdg_result_if.sv]
// Result output channel: one decoded number per beat.
`timescale 1ns / 1ps

interface ctcdg_result_if;
	logic                             valid;
	logic                             ready;
	logic [ctcdg_pkg::NUMBER_W-1:0]   number;
	logic                             overflow;

	modport source (output valid, output number, output overflow, input ready);
	modport sink (input valid, input number, input overflow, output ready);
endinterface

[rtl/ctcdg_queue.sv]
// Short register queue of closed timesteps between the front and back parts.
`timescale 1ns / 1ps

module ctcdg_queue #(
	parameter int unsigned WIDTH = 5,
	parameter int unsigned DEPTH = ctcdg_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     head_data,
	output ctcdg_pkg::q_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Status and head entry.
	always_comb begin
		status.valid = (count_q != '0);
		status.full  = (count_q == CNT_W'(DEPTH));
		head_data    = entry_q[rd_ptr_q];
	end

	// Storage; written on every push, which the front part gives only while not full.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/ctcdg_front.sv]
// Front part: running argmax over the class scores of each timestep.
`timescale 1ns / 1ps

module ctcdg_front #(
	parameter int unsigned MAX_CLASSES = ctcdg_pkg::DEFAULT_MAX_CLASSES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ctcdg_score_if.sink                  scores,
	input  ctcdg_pkg::q_status_t         q_status,
	output logic                         push,
	output logic [$clog2(MAX_CLASSES):0] push_data
);

	localparam int unsigned IDX_W = $clog2(MAX_CLASSES);
	localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);

	logic [CNT_W-1:0]                     class_index_q;
	logic signed [ctcdg_pkg::SCORE_W-1:0] best_score_q;
	logic [IDX_W-1:0]                     best_index_q;

	logic                                 beat;
	logic                                 first;
	logic                                 in_range;
	logic                                 take;
	logic [IDX_W-1:0]                     cand_index;

	assign scores.ready = !q_status.full;
	assign beat         = scores.valid && scores.ready;

	// Argmax step: the first score opens the timestep, later ones win only when
	// strictly greater, and scores past the last class slot are ignored.
	always_comb begin
		first      = (class_index_q == '0);
		in_range   = (class_index_q < CNT_W'(MAX_CLASSES));
		take       = first || (in_range && (scores.score > best_score_q));
		if (first) begin
			cand_index = '0;
		end else if (take) begin
			cand_index = class_index_q[IDX_W-1:0];
		end else begin
			cand_index = best_index_q;
		end
		push      = beat && scores.class_last;
		push_data = {scores.step_last, cand_index};
	end

	// Per-timestep search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_index_q <= '0;
			best_score_q  <= '0;
			best_index_q  <= '0;
		end else if (beat) begin
			if (scores.class_last) begin
				class_index_q <= '0;
				best_score_q  <= '0;
				best_index_q  <= '0;
			end else begin
				if (in_range && (class_index_q < CNT_W'(MAX_CLASSES - 1))) begin
					class_index_q <= class_index_q + 1'b1;
				end else begin
					class_index_q <= CNT_W'(MAX_CLASSES);
				end
				if (take) begin
					best_score_q <= scores.score;
				end
				best_index_q <= cand_index;
			end
		end
	end

endmodule

[rtl/ctcdg_back.sv]
// Back part: CTC collapse, saturating decimal accumulation and result register.
`timescale 1ns / 1ps

module ctcdg_back #(
	parameter int unsigned MAX_CLASSES = ctcdg_pkg::DEFAULT_MAX_CLASSES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctcdg_pkg::q_status_t         q_status,
	input  logic [$clog2(MAX_CLASSES):0] head_data,
	output logic                         pop,
	ctcdg_result_if.source               results
);

	localparam int unsigned IDX_W  = $clog2(MAX_CLASSES);
	localparam int unsigned WIDE_W = ctcdg_pkg::WIDE_W;
	localparam int unsigned NUM_W  = ctcdg_pkg::NUMBER_W;

	logic [NUM_W-1:0]  acc_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  prev_q;
	logic              out_valid_q;
	logic [NUM_W-1:0]  number_q;
	logic              overflow_q;

	logic              head_last;
	logic [IDX_W-1:0]  head_idx;
	logic              keep;
	logic [WIDE_W-1:0] next_wide;
	logic [NUM_W-1:0]  new_acc;
	logic              new_ovf;

	assign head_last = head_data[IDX_W];
	assign head_idx  = head_data[IDX_W-1:0];

	// A closing symbol may leave the queue only when the result register is free or its result is taken.
	assign pop = q_status.valid && (!head_last || !out_valid_q || results.ready);

	assign results.valid    = out_valid_q;
	assign results.number   = number_q;
	assign results.overflow = overflow_q;

	// Collapse and accumulate: acc * 10 as two shifted adds, plus index - 1.
	always_comb begin
		keep      = (head_idx != IDX_W'(ctcdg_pkg::BLANK_INDEX)) && (head_idx != prev_q);
		next_wide = ({acc_q, 3'b000} + WIDE_W'({acc_q, 1'b0}))
			+ WIDE_W'(head_idx - 1'b1);
		new_acc   = acc_q;
		new_ovf   = ovf_q;
		if (keep) begin
			if (ovf_q || (next_wide > WIDE_W'(ctcdg_pkg::NUMBER_MAX))) begin
				new_acc = ctcdg_pkg::NUMBER_MAX;
				new_ovf = 1'b1;
			end else begin
				new_acc = next_wide[NUM_W-1:0];
			end
		end
	end

	// Sequence state; cleared after the closing timestep of a sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			ovf_q  <= 1'b0;
			prev_q <= IDX_W'(ctcdg_pkg::BLANK_INDEX);
		end else if (pop) begin
			if (head_last) begin
				acc_q  <= '0;
				ovf_q  <= 1'b0;
				prev_q <= IDX_W'(ctcdg_pkg::BLANK_INDEX);
			end else begin
				acc_q  <= new_acc;
				ovf_q  <= new_ovf;
				prev_q <= head_idx;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head_last) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop && head_last) begin
			number_q   <= new_acc;
			overflow_q <= new_ovf;
		end
	end

endmodule

[rtl/ctc_digit_greedy_decoder_unit.sv]
// Top level of the CTC greedy digit decoder.
// A closing beat goes through the queue and is popped into the result register.
// Throughput: one score beat per cycle unless the queue is full, set by the argmax
// compare in the front and the multiply-add and saturation check in the back.
// Reset: arst_n clears the search, queue, accumulator and result flag at once.
`timescale 1ns / 1ps

module ctc_digit_greedy_decoder_unit #(
	parameter int unsigned MAX_CLASSES = ctcdg_pkg::DEFAULT_MAX_CLASSES
) (
	input  logic           clk,
	input  logic           arst_n,
	ctcdg_score_if.sink    scores,
	ctcdg_result_if.source results
);

	localparam int unsigned ENTRY_W = $clog2(MAX_CLASSES) + 1;

	ctcdg_pkg::q_status_t q_status;
	logic                 push;
	logic [ENTRY_W-1:0]   push_data;
	logic                 pop;
	logic [ENTRY_W-1:0]   head_data;

	// Argmax per timestep.
	ctcdg_front #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.scores    (scores),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	// Closed timesteps waiting for the back part.
	ctcdg_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (ctcdg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.status    (q_status)
	);

	// Collapse, accumulate and deliver.
	ctcdg_back #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head_data (head_data),
		.pop       (pop),
		.results   (results)
	);

endmodule

[rtl/ctcdg_checker.sv]
// Port-level assertions of the CTC digit decoder and their bind.
`timescale 1ns / 1ps
`include "ctc_digit_greedy_decoder_unit_macros.svh"

module ctcdg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           score_valid,
	input logic                           score_ready,
	input logic                           class_last,
	input logic                           step_last,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [ctcdg_pkg::NUMBER_W-1:0] number,
	input logic                           overflow
);

	// A stalled result beat holds.
	`CTCDG_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(number) && $stable(overflow))

	// An overflowed result always carries the saturated number.
	`CTCDG_ASSERT_NOW(a_overflow_saturates, result_valid && overflow, number == ctcdg_pkg::NUMBER_MAX)

	// A result rising from idle comes from an earlier sequence-closing beat.
	`CTCDG_ASSERT_NOW(a_result_from_close, $rose(result_valid), $past(score_valid && score_ready && class_last && step_last, 2))

endmodule

bind ctc_digit_greedy_decoder_unit ctcdg_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.score_valid  (scores.valid),
	.score_ready  (scores.ready),
	.class_last   (scores.class_last),
	.step_last    (scores.step_last),
	.result_valid (results.valid),
	.result_ready (results.ready),
	.number       (results.number),
	.overflow     (results.overflow)
);

[test/ctc_digit_greedy_decoder_unit_tb.sv]
// Self-checking testbench for the CTC greedy digit decoder: directed table, then random sequences.
`timescale 1ns / 1ps

module ctc_digit_greedy_decoder_unit_tb;

	localparam int MAX_CLASSES  = ctcdg_pkg::DEFAULT_MAX_CLASSES;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BEATS  = 275;
	localparam int PHASE_NUMS   = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int N_DIRECTED   = 25;

	// Idle and stall percentages of the sender and receiver in each phase.
	localparam int SRC_IDLE [4] = '{0, 68, 0, 9};
	localparam int SNK_STALL [4] = '{0, 0, 68, 9};

	typedef struct packed {
		logic [ctcdg_pkg::NUMBER_W-1:0] number;
		logic                           overflow;
	} decoded_t;

	// One score beat, with an optional result typed in by hand.
	typedef struct packed {
		logic signed [ctcdg_pkg::SCORE_W-1:0] score;
		logic                                 class_last;
		logic                                 step_last;
		logic                                 pinned;
		decoded_t                             pin;
	} score_beat_t;

	typedef enum int {
		SHAPE_PLAIN,
		SHAPE_LONG,
		SHAPE_NOISE
	} seq_shape_e;

	// Directed table: a lone blank sequence, an over-long timestep with ties and a
	// digit above nine, a tied blank, a kept digit, a dropped repeat, a blank end.
	localparam score_beat_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{8'sh80,    1'b1, 1'b1, 1'b1, '{31'd0, 1'b0}},
		'{8'sh80,    1'b0, 1'b0, 1'b0, '0},
		'{8'sd0,     1'b0, 1'b0, 1'b0, '0},
		'{-8'sd1,    1'b0, 1'b0, 1'b0, '0},
		'{8'sd20,    1'b0, 1'b1, 1'b0, '0},
		'{8'sd19,    1'b0, 1'b0, 1'b0, '0},
		'{-8'sd50,   1'b0, 1'b0, 1'b0, '0},
		'{8'sd100,   1'b0, 1'b0, 1'b0, '0},
		'{8'sd99,    1'b0, 1'b0, 1'b0, '0},
		'{8'sd0,     1'b0, 1'b0, 1'b0, '0},
		'{-8'sd127,  1'b0, 1'b0, 1'b0, '0},
		'{8'sd100,   1'b0, 1'b0, 1'b0, '0},
		'{8'sd126,   1'b0, 1'b0, 1'b0, '0},
		'{8'sd126,   1'b0, 1'b1, 1'b0, '0},
		'{8'sd5,     1'b0, 1'b0, 1'b0, '0},
		'{8'sd125,   1'b0, 1'b0, 1'b0, '0},
		'{8'sd126,   1'b0, 1'b0, 1'b0, '0},
		'{8'sd127,   1'b1, 1'b0, 1'b0, '0},
		'{8'sd5,     1'b0, 1'b0, 1'b0, '0},
		'{8'sd5,     1'b1, 1'b0, 1'b0, '0},
		'{-8'sd1,    1'b0, 1'b0, 1'b0, '0},
		'{8'sd0,     1'b1, 1'b0, 1'b0, '0},
		'{-8'sd5,    1'b0, 1'b0, 1'b0, '0},
		'{8'sd3,     1'b1, 1'b0, 1'b0, '0},
		'{8'sd7,     1'b1, 1'b1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	ctcdg_score_if  score_ch ();
	ctcdg_result_if result_ch ();

	ctc_digit_greedy_decoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.scores  (score_ch),
		.results (result_ch)
	);

	// Decoder state mirrored by the testbench.
	int                                   cur_class   = 0;
	logic signed [ctcdg_pkg::SCORE_W-1:0] top_score   = '0;
	int                                   top_class   = 0;
	int                                   last_symbol = ctcdg_pkg::BLANK_INDEX;
	logic [ctcdg_pkg::NUMBER_W-1:0]       number_acc  = '0;
	logic                                 number_sat  = 1'b0;

	decoded_t    expected_numbers [$];
	score_beat_t stim_beats [$];
	score_beat_t presented_beat;
	int          src_idle_pct  = 0;
	int          snk_stall_pct = 0;
	int          mismatches    = 0;
	int          cycle_count   = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Running argmax, CTC collapse and saturating decimal accumulation.
	function automatic bit decode_beat(input logic signed [ctcdg_pkg::SCORE_W-1:0] s,
			input logic cl, input logic sl, output decoded_t res);
		bit              counted;
		longint unsigned grown;
		counted = 1'b0;
		res = '0;
		if (cur_class == 0) begin
			top_score = s;
			top_class = 0;
			counted = 1'b1;
		end else if (cur_class < MAX_CLASSES) begin
			if (s > top_score) begin
				top_score = s;
				top_class = cur_class;
			end
			counted = 1'b1;
		end
		if (!cl) begin
			if (counted && cur_class < MAX_CLASSES - 1)
				cur_class++;
			else
				cur_class = MAX_CLASSES;
			return 1'b0;
		end
		// The timestep closes: blanks and repeats add nothing.
		if (top_class != ctcdg_pkg::BLANK_INDEX && top_class != last_symbol) begin
			grown = 64'(number_acc) * ctcdg_pkg::DECIMAL_BASE + 64'(top_class - 1);
			if (number_sat || grown > 64'(ctcdg_pkg::NUMBER_MAX)) begin
				number_acc = ctcdg_pkg::NUMBER_MAX;
				number_sat = 1'b1;
			end else begin
				number_acc = grown[ctcdg_pkg::NUMBER_W-1:0];
			end
		end
		last_symbol = top_class;
		cur_class = 0;
		top_score = '0;
		top_class = 0;
		if (!sl)
			return 1'b0;
		res.number = number_acc;
		res.overflow = number_sat;
		number_acc = '0;
		number_sat = 1'b0;
		last_symbol = ctcdg_pkg::BLANK_INDEX;
		return 1'b1;
	endfunction

	// Appends one timestep; a planted winner gets the only positive score.
	task automatic queue_timestep(input int n_cls, input int winner, input bit narrow,
			input bit seq_end);
		score_beat_t b;
		for (int k = 0; k < n_cls; k++) begin
			b = '0;
			if (winner >= 0)
				b.score = (k == winner) ? 8'($urandom_range(127, 1))
					: 8'(256 - $urandom_range(128, 1));
			else if (narrow)
				b.score = 8'($urandom_range(4) - 2);
			else
				b.score = 8'($urandom_range(255));
			b.class_last = (k == n_cls - 1);
			b.step_last = b.class_last ? seq_end : ($urandom_range(7) == 0);
			stim_beats = {stim_beats, b};
		end
	endtask

	// Appends one whole sequence that ends with the closing beat.
	task automatic queue_sequence();
		seq_shape_e shape;
		int         pick;
		int         steps;
		int         n_cls;
		int         winner;
		int         prev_winner;
		pick = $urandom_range(99);
		shape = (pick < 70) ? SHAPE_PLAIN : (pick < 80) ? SHAPE_LONG : SHAPE_NOISE;
		steps = (shape == SHAPE_LONG) ? $urandom_range(14, 10) : $urandom_range(6, 1);
		prev_winner = ctcdg_pkg::BLANK_INDEX;
		for (int st = 0; st < steps; st++) begin
			case (shape)
				SHAPE_PLAIN: begin
					pick = $urandom_range(99);
					n_cls = (pick < 85) ? $urandom_range(11, 1)
						: (pick < 95) ? $urandom_range(16, 12) : $urandom_range(20, 17);
					winner = ($urandom_range(3) == 0) ? -1 : $urandom_range(n_cls - 1);
					queue_timestep(n_cls, winner, $urandom_range(3) == 0, st == steps - 1);
				end
				// Distinct non-blank winners in a row drive the number into saturation.
				SHAPE_LONG: begin
					do
						winner = $urandom_range(MAX_CLASSES - 1, 1);
					while (winner == prev_winner);
					prev_winner = winner;
					n_cls = winner + 1 + $urandom_range(2);
					queue_timestep(n_cls, winner, 1'b0, st == steps - 1);
				end
				default: begin
					n_cls = $urandom_range(20, 1);
					queue_timestep(n_cls, -1, $urandom_range(1) == 1, st == steps - 1);
				end
			endcase
		end
	endtask

	// Presents one beat after a random gap and holds it until it is taken.
	task automatic push_beat(input score_beat_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			score_ch.valid <= 1'b0;
			@(posedge clk);
		end
		score_ch.valid <= 1'b1;
		score_ch.score <= b.score;
		score_ch.class_last <= b.class_last;
		score_ch.step_last <= b.step_last;
		presented_beat <= b;
		@(posedge clk);
		while (!score_ch.ready)
			@(posedge clk);
	endtask

	// Predicts on every accepted score beat and checks every accepted result beat.
	always @(posedge clk) begin : track_results
		decoded_t pred;
		decoded_t want;
		if (arst_n) begin
			if (score_ch.valid && score_ch.ready) begin
				if (decode_beat(score_ch.score, score_ch.class_last, score_ch.step_last, pred))
					expected_numbers = {expected_numbers,
						presented_beat.pinned ? presented_beat.pin : pred};
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_numbers.size() == 0) begin
					$display("%0t: unexpected result number %0d overflow %0b", $time,
						result_ch.number, result_ch.overflow);
					mismatches++;
				end else begin
					want = expected_numbers.pop_front();
					if (result_ch.number !== want.number) begin
						$display("%0t: number expected %0d actual %0d", $time, want.number,
							result_ch.number);
						mismatches++;
					end
					if (result_ch.overflow !== want.overflow) begin
						$display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
							result_ch.overflow);
						mismatches++;
					end
				end
			end
		end
		result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int phase_beats;
		int phase_nums;
		arst_n = 1'b0;
		score_ch.valid = 1'b0;
		score_ch.score = '0;
		score_ch.class_last = 1'b0;
		score_ch.step_last = 1'b0;
		result_ch.ready = 1'b0;
		presented_beat = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int r = 0; r < N_DIRECTED; r++)
			push_beat(DIRECTED_ROWS[r]);

		// Random sequences in phases of sender and receiver pressure.
		for (int ph = 0; ph < 4; ph++) begin
			// The sender pauses until every pending number has come back; the extra
			// edge lets the tracker record the last closing beat first.
			score_ch.valid <= 1'b0;
			@(posedge clk);
			while (expected_numbers.size() != 0)
				@(posedge clk);
			src_idle_pct = SRC_IDLE[ph];
			snk_stall_pct = SNK_STALL[ph];
			phase_beats = 0;
			phase_nums = 0;
			while (phase_beats < PHASE_BEATS || phase_nums < PHASE_NUMS) begin
				queue_sequence();
				phase_nums++;
				while (stim_beats.size() != 0) begin
					push_beat(stim_beats.pop_front());
					phase_beats++;
				end
			end
		end
		score_ch.valid <= 1'b0;
		@(posedge clk);

		while (expected_numbers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/ctcdg_pkg.sv
rtl/ctcdg_score_if.sv
rtl/ctcdg_result_if.sv
rtl/ctcdg_queue.sv
rtl/ctcdg_front.sv
rtl/ctcdg_back.sv
rtl/ctc_digit_greedy_decoder_unit.sv
rtl/ctcdg_checker.sv
test/ctc_digit_greedy_decoder_unit_tb.sv
